// ===== src/des_rks_pkg.sv =====
`timescale 1ns / 1ps
// des_rks_pkg: permuted choice tables, rotation schedule and selection functions
// for the des round key schedule; no dependencies
package des_rks_pkg;

    localparam int KeyW   = 64;
    localparam int HalfW  = 28;
    localparam int CdW    = 56;
    localparam int SubW   = 48;
    localparam int Rounds = 16;
    localparam int RoundW = 4;
    localparam int NumW   = 5;

    // first permuted choice, des bit numbers counted from the key msb
    localparam byte unsigned PC1_TAB [CdW] = '{
        8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,
        8'd1,  8'd58, 8'd50, 8'd42, 8'd34, 8'd26, 8'd18,
        8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27,
        8'd19, 8'd11, 8'd3,  8'd60, 8'd52, 8'd44, 8'd36,
        8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15,
        8'd7,  8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22,
        8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37, 8'd29,
        8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
    };

    // second permuted choice, des bit numbers counted from the msb of c:d
    localparam byte unsigned PC2_TAB [SubW] = '{
        8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,
        8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
        8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,
        8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
        8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55,
        8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
        8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53,
        8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
    };

    // set for each round that rotates by two places, first round at the lsb
    localparam logic [Rounds-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

    function automatic logic [CdW-1:0] pc1(input logic [KeyW-1:0] key);
        logic [CdW-1:0] sel;
        logic [5:0]     idx;
        sel = '0;
        for (int i = 0; i < CdW; i++)
        begin
            idx = 6'(KeyW - int'(PC1_TAB[i]));
            sel[CdW-1-i] = key[idx];
        end
        return sel;
    endfunction

    function automatic logic [SubW-1:0] pc2(input logic [CdW-1:0] cd);
        logic [SubW-1:0] sub;
        logic [5:0]      idx;
        sub = '0;
        for (int i = 0; i < SubW; i++)
        begin
            idx = 6'(CdW - int'(PC2_TAB[i]));
            sub[SubW-1-i] = cd[idx];
        end
        return sub;
    endfunction

endpackage

// ===== src/des_rks_round.sv =====
`timescale 1ns / 1ps
// des_rks_round: one key schedule round, rotate both halves and apply pc2
// depends on des_rks_pkg
module des_rks_round
(
    input  logic [des_rks_pkg::HalfW-1:0] c_in,
    input  logic [des_rks_pkg::HalfW-1:0] d_in,
    input  logic                          two,
    output logic [des_rks_pkg::HalfW-1:0] c_out,
    output logic [des_rks_pkg::HalfW-1:0] d_out,
    output logic [des_rks_pkg::SubW-1:0]  sub
);

    always_comb
    begin
        if (two)
        begin
            c_out = {c_in[des_rks_pkg::HalfW-3:0], c_in[des_rks_pkg::HalfW-1 -: 2]};
            d_out = {d_in[des_rks_pkg::HalfW-3:0], d_in[des_rks_pkg::HalfW-1 -: 2]};
        end
        else
        begin
            c_out = {c_in[des_rks_pkg::HalfW-2:0], c_in[des_rks_pkg::HalfW-1]};
            d_out = {d_in[des_rks_pkg::HalfW-2:0], d_in[des_rks_pkg::HalfW-1]};
        end
        sub = des_rks_pkg::pc2({c_out, d_out});
    end

endmodule

// ===== src/des_round_key_schedule_unit.sv =====
`timescale 1ns / 1ps
// des_round_key_schedule_unit: top level, takes a des key and delivers its sixteen subkeys
// depends on des_rks_pkg and des_rks_round
//
//   channel   direction  handshake                  payload
//   key       in         key_valid / key_ready      key[63:0]
//   round     out        round_valid / round_ready  round_key[47:0], round_number[4:0],
//                                                   last_round
//
// a key beat loads pc1(key) into the c/d registers; the shared round
// unit then makes one rotation and one subkey per cycle while the output side does not
// stall, sixteen in all, and a new key is taken only once the last subkey is made
// the round unit is a single instance reused once per round
// a stall on the round channel holds the round unit until the output register frees up
// reset clears the sequencer and output valid; c/d and output payload are not reset
module des_round_key_schedule_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        key_valid,
    output logic        key_ready,
    input  logic [63:0] key,
    output logic        round_valid,
    input  logic        round_ready,
    output logic [47:0] round_key,
    output logic [4:0]  round_number,
    output logic        last_round
);

    // sequencer states, one-hot
    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // key halves under rotation
    logic [des_rks_pkg::HalfW-1:0] c_reg, c_next;
    logic [des_rks_pkg::HalfW-1:0] d_reg, d_next;

    // which round the shared unit works on next, 0 to 15
    logic [des_rks_pkg::RoundW-1:0] round_cnt_reg, round_cnt_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [des_rks_pkg::SubW-1:0]  out_key_reg, out_key_next;
    logic [des_rks_pkg::NumW-1:0]  out_num_reg, out_num_next;
    logic                          out_last_reg, out_last_next;

    // shared round unit results
    logic [des_rks_pkg::HalfW-1:0] c_rot;
    logic [des_rks_pkg::HalfW-1:0] d_rot;
    logic [des_rks_pkg::SubW-1:0]  sub;

    logic [des_rks_pkg::CdW-1:0]   pc1_sel;
    logic                          key_fire;
    logic                          out_free;
    logic                          step;

    des_rks_round u_round
    (
        .c_in  (c_reg),
        .d_in  (d_reg),
        .two   (des_rks_pkg::ROT_TWO[round_cnt_reg]),
        .c_out (c_rot),
        .d_out (d_rot),
        .sub   (sub)
    );

    assign pc1_sel   = des_rks_pkg::pc1(key);
    assign key_ready = (state_reg == ST_IDLE);
    assign key_fire  = key_valid && key_ready;

    // output register can take a new subkey when empty or being drained this cycle
    assign out_free  = !out_valid_reg || round_ready;
    assign step      = (state_reg == ST_RUN) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        round_cnt_next = round_cnt_reg;
        out_valid_next = out_valid_reg;
        out_key_next   = out_key_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;

        // beat taken downstream
        if (out_valid_reg && round_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (key_fire)
                begin
                    c_next         = pc1_sel[des_rks_pkg::CdW-1:des_rks_pkg::HalfW];
                    d_next         = pc1_sel[des_rks_pkg::HalfW-1:0];
                    round_cnt_next = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    c_next         = c_rot;
                    d_next         = d_rot;
                    out_valid_next = 1'b1;
                    out_key_next   = sub;
                    out_num_next   = {1'b0, round_cnt_reg} + 5'd1;
                    out_last_next  = (round_cnt_reg == 4'(des_rks_pkg::Rounds - 1));
                    round_cnt_next = round_cnt_reg + 4'd1;
                    if (round_cnt_reg == 4'(des_rks_pkg::Rounds - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_cnt_reg <= round_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        c_reg        <= c_next;
        d_reg        <= d_next;
        out_key_reg  <= out_key_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    assign round_valid  = out_valid_reg;
    assign round_key    = out_key_reg;
    assign round_number = out_num_reg;
    assign last_round   = out_last_reg;

    // a key beat starts the sequencer at round one
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        key_fire |=> (state_reg == ST_RUN) && (round_cnt_reg == '0))
        else $error("sequencer did not start at round one after a key beat");

    // last flag marks exactly the sixteenth subkey
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        round_valid |-> (last_round == (round_number == 5'd16)))
        else $error("last_round does not match round_number");

    // subkeys of one key follow each other without gaps in numbering
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (round_valid && round_ready && !last_round)
            |=> round_valid && (round_number == $past(round_number) + 5'd1))
        else $error("subkey round numbers out of sequence");

endmodule
